### rtl/oma_pkg.sv
// Shared constants and codes for the object merge accumulator.
`timescale 1ns / 1ps
`default_nettype none

package oma_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);

    localparam int VAL_W       = 16;   // positions, heights, means
    localparam int NCNT_W      = 16;   // sample count
    localparam int CLS_W       = 8;
    localparam int RAD_W       = 33;
    localparam int CMD_W       = 2;
    localparam int STS_W       = 3;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(23593);

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [STS_W-1:0] ST_MERGED   = 3'd0;
    localparam logic [STS_W-1:0] ST_ADDED    = 3'd1;
    localparam logic [STS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STS_W-1:0] ST_CLEARED  = 3'd3;
    localparam logic [STS_W-1:0] ST_READ_OK  = 3'd4;
    localparam logic [STS_W-1:0] ST_READ_BAD = 3'd5;

endpackage

`default_nettype wire

### rtl/object_merge_accumulator.sv
// Top level: object table in two entry memories, scan pipeline and merge sequencer.
// Flow: an add scans the occupied entries, then merges into the first match, appends a
//   fresh entry, or is dropped on a full table; a merge passes 3 scan stages, re-read,
//   launch and the mean lanes; a read re-reads the entry (skipped for an unused index).
// Throughput: one item at a time, set by the one-entry-per-cycle scan and the 16-step
//   divider; a held result stalls input.
// Reset clears the occupied count, the FSMs and the output valid and sets the radius
//   to 23593; entry memories are not cleared, only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module object_merge_accumulator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [oma_pkg::RAD_W-1:0]  i_cfg_wr_data,   // merge_radius_sq
    // input items
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] obj_class, [23:8] x_pos, [39:24] y_pos, [55:40] z_pos,
    // [71:56] obj_height, [77:72] read_index, [79:78] zero
    input  wire logic [79:0]                s_axis_tdata,
    // [1:0] command
    input  wire logic [oma_pkg::CMD_W-1:0]  s_axis_tuser,
    // result items
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [5:0] entry_index, [13:6] entry_class, [29:14] mean_x, [45:30] mean_y,
    // [61:46] mean_z, [77:62] mean_height, [93:78] sample_count,
    // [100:94] entries_used, [103:101] zero
    output logic [103:0]                    m_axis_tdata,
    // [2:0] status
    output logic [oma_pkg::STS_W-1:0]       m_axis_tuser
);
    import oma_pkg::*;

    localparam int POS_W  = 3 * VAL_W;                  // {z, y, x}
    localparam int CHC_W  = CLS_W + VAL_W + NCNT_W;     // {count, height, class}
    localparam int DX_W   = VAL_W + 1;
    localparam int SQ_W   = 2 * VAL_W;
    localparam int LANES  = 4;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SCAN = 8'b00000010,   // streaming compare over occupied entries
        S_MRD  = 8'b00000100,   // re-read the matched entry
        S_MLD  = 8'b00001000,   // launch the mean lanes
        S_MDIV = 8'b00010000,   // wait for the lanes, write back
        S_RRD  = 8'b00100000,
        S_RLD  = 8'b01000000,
        S_DONE = 8'b10000000    // hand result to the output register
    } t_state;

    t_state                 r_state, n_state;

    // ---------------------------------------------------------------------
    // Item fields, config
    // ---------------------------------------------------------------------
    logic                   in_acc;
    logic [CLS_W-1:0]       in_cls;
    logic [VAL_W-1:0]       in_x, in_y, in_z, in_h;
    logic [IDX_W-1:0]       in_ridx;

    assign in_cls  = s_axis_tdata[7:0];
    assign in_x    = s_axis_tdata[23:8];
    assign in_y    = s_axis_tdata[39:24];
    assign in_z    = s_axis_tdata[55:40];
    assign in_h    = s_axis_tdata[71:56];
    assign in_ridx = s_axis_tdata[77:72];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    logic [RAD_W-1:0]       r_radius;
    logic [CLS_W-1:0]       r_cls;
    logic signed [VAL_W-1:0] r_x, r_y, r_z, r_h;
    logic [IDX_W-1:0]       r_ridx;
    logic [OCC_W-1:0]       r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cls  <= in_cls;
            r_x    <= in_x;
            r_y    <= in_y;
            r_z    <= in_z;
            r_h    <= in_h;
            r_ridx <= in_ridx;
        end
    end

    // ---------------------------------------------------------------------
    // Entry memories: one read port with registered data, one write port
    // ---------------------------------------------------------------------
    logic [POS_W-1:0]       r_pos_mem [TABLE_DEPTH];
    logic [CHC_W-1:0]       r_chc_mem [TABLE_DEPTH];
    logic [POS_W-1:0]       r_pos_q;
    logic [CHC_W-1:0]       r_chc_q;

    logic                   rd_en, wr_en;
    logic [IDX_W-1:0]       rd_addr, wr_addr;
    logic [POS_W-1:0]       wr_pos;
    logic [CHC_W-1:0]       wr_chc;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pos_q <= r_pos_mem[rd_addr];
            r_chc_q <= r_chc_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pos_mem[wr_addr] <= wr_pos;
            r_chc_mem[wr_addr] <= wr_chc;
        end
    end

    // ---------------------------------------------------------------------
    // Scan pipeline: issue read -> square distances -> sum and compare
    // ---------------------------------------------------------------------
    logic [OCC_W-1:0]       r_issue;
    logic                   r_v1, r_v2;
    logic [IDX_W-1:0]       r_i1, r_i2, r_hit_idx;
    logic [SQ_W-1:0]        r_sqx, r_sqz;

    logic                   scan_issue, scan_hit, scan_end, cls_eq;
    logic signed [DX_W-1:0] dx, dz;
    logic signed [2*DX_W-1:0] sqx, sqz;
    logic [RAD_W-1:0]       d2;

    assign cls_eq = (r_chc_q[CLS_W-1:0] == r_cls);
    assign dx     = DX_W'($signed(r_pos_q[VAL_W-1:0])) - DX_W'(r_x);
    assign dz     = DX_W'($signed(r_pos_q[3*VAL_W-1:2*VAL_W])) - DX_W'(r_z);
    assign sqx    = dx * dx;
    assign sqz    = dz * dz;
    assign d2     = {1'b0, r_sqx} + {1'b0, r_sqz};

    // first match in entry order wins; later entries still in flight are dropped
    assign scan_hit   = (r_state == S_SCAN) && r_v2 && (d2 <= r_radius);
    assign scan_issue = (r_state == S_SCAN) && !scan_hit && (r_issue < r_occ);
    assign scan_end   = (r_state == S_SCAN) && !scan_hit && (r_issue >= r_occ)
                        && !r_v1 && !r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= scan_issue;
            r_v2 <= (r_state == S_SCAN) && !scan_hit && r_v1 && cls_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= r_issue[IDX_W-1:0];
        r_i2  <= r_i1;
        r_sqx <= sqx[SQ_W-1:0];
        r_sqz <= sqz[SQ_W-1:0];
        if (in_acc) begin
            r_issue <= '0;
        end else if (scan_issue) begin
            r_issue <= r_issue + OCC_W'(1);
        end
        if (scan_hit) begin
            r_hit_idx <= r_i2;
        end
    end

    // ---------------------------------------------------------------------
    // Running-mean lanes: x, y, z, height
    // ---------------------------------------------------------------------
    logic                    lane_start;
    logic [LANES-1:0]        lane_done;
    logic signed [VAL_W-1:0] lane_old  [LANES];
    logic signed [VAL_W-1:0] lane_new  [LANES];
    logic signed [VAL_W-1:0] lane_val  [LANES];

    assign lane_start  = (r_state == S_MLD);
    assign lane_old[0] = r_pos_q[VAL_W-1:0];
    assign lane_old[1] = r_pos_q[2*VAL_W-1:VAL_W];
    assign lane_old[2] = r_pos_q[3*VAL_W-1:2*VAL_W];
    assign lane_old[3] = r_chc_q[CLS_W+VAL_W-1:CLS_W];
    assign lane_val[0] = r_x;
    assign lane_val[1] = r_y;
    assign lane_val[2] = r_z;
    assign lane_val[3] = r_h;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        oma_mean u_mean (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (lane_start),
            .i_mean  (lane_old[g]),
            .i_cnt   (r_chc_q[CHC_W-1:CLS_W+VAL_W]),
            .i_val   (lane_val[g]),
            .o_done  (lane_done[g]),
            .o_mean  (lane_new[g])
        );
    end

    // ---------------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------------
    logic                   lanes_done;
    logic                   out_free;
    logic [NCNT_W-1:0]      r_new_cnt;
    logic [NCNT_W-1:0]      old_cnt;
    logic                   table_full;

    // result staging registers
    logic [STS_W-1:0]        r_res_status;
    logic [IDX_W-1:0]        r_res_idx;
    logic [CLS_W-1:0]        r_res_class;
    logic [VAL_W-1:0]        r_res_x, r_res_y, r_res_z, r_res_h;
    logic [NCNT_W-1:0]       r_res_cnt;
    logic [OCC_W-1:0]        r_res_used;

    assign lanes_done = &lane_done;
    assign out_free   = !m_axis_tvalid || m_axis_tready;
    assign old_cnt    = r_chc_q[CHC_W-1:CLS_W+VAL_W];
    assign table_full = (r_occ >= OCC_W'(TABLE_DEPTH));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (s_axis_tuser)
                        CMD_ADD:   n_state = S_SCAN;
                        CMD_CLEAR: n_state = S_DONE;
                        CMD_READ:  n_state = ({1'b0, in_ridx} < r_occ) ? S_RRD : S_DONE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_MRD;
                end else if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_MRD:   n_state = S_MLD;
            S_MLD:   n_state = S_MDIV;
            S_MDIV:  if (lanes_done) n_state = S_DONE;
            S_RRD:   n_state = S_RLD;
            S_RLD:   n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port steering
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_issue[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_hit_idx;
        wr_pos  = {lane_new[2], lane_new[1], lane_new[0]};
        wr_chc  = {r_new_cnt, lane_new[3], r_res_class};
        case (r_state)
            S_SCAN: begin
                rd_en = scan_issue;
                if (scan_end && !table_full) begin
                    // append a fresh entry with a count of one
                    wr_en   = 1'b1;
                    wr_addr = r_occ[IDX_W-1:0];
                    wr_pos  = {r_z, r_y, r_x};
                    wr_chc  = {NCNT_W'(1), r_h, r_cls};
                end
            end
            S_MRD: begin
                rd_en   = 1'b1;
                rd_addr = r_hit_idx;
            end
            S_MDIV: begin
                wr_en = lanes_done;
            end
            S_RRD: begin
                rd_en   = 1'b1;
                rd_addr = r_ridx;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc && s_axis_tuser == CMD_CLEAR) begin
                r_occ <= '0;
            end else if (scan_end && !table_full) begin
                r_occ <= r_occ + OCC_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result staging
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // clear and unused-index read settle here; zero payload
                r_res_status <= (s_axis_tuser == CMD_CLEAR) ? ST_CLEARED : ST_READ_BAD;
                r_res_idx    <= (s_axis_tuser == CMD_CLEAR) ? '0 : in_ridx;
                r_res_class  <= '0;
                r_res_x      <= '0;
                r_res_y      <= '0;
                r_res_z      <= '0;
                r_res_h      <= '0;
                r_res_cnt    <= '0;
                r_res_used   <= (s_axis_tuser == CMD_CLEAR) ? '0 : r_occ;
            end
            S_SCAN: begin
                if (scan_end) begin
                    if (!table_full) begin
                        r_res_status <= ST_ADDED;
                        r_res_idx    <= r_occ[IDX_W-1:0];
                        r_res_class  <= r_cls;
                        r_res_x      <= r_x;
                        r_res_y      <= r_y;
                        r_res_z      <= r_z;
                        r_res_h      <= r_h;
                        r_res_cnt    <= NCNT_W'(1);
                        r_res_used   <= r_occ + OCC_W'(1);
                    end else begin
                        r_res_status <= ST_DROPPED;
                        r_res_idx    <= '0;
                        r_res_class  <= '0;
                        r_res_x      <= '0;
                        r_res_y      <= '0;
                        r_res_z      <= '0;
                        r_res_h      <= '0;
                        r_res_cnt    <= '0;
                        r_res_used   <= r_occ;
                    end
                end
            end
            S_MLD: begin
                r_res_class <= r_chc_q[CLS_W-1:0];
                r_new_cnt   <= (old_cnt == '1) ? old_cnt : old_cnt + NCNT_W'(1);
            end
            S_MDIV: begin
                r_res_status <= ST_MERGED;
                r_res_idx    <= r_hit_idx;
                r_res_x      <= lane_new[0];
                r_res_y      <= lane_new[1];
                r_res_z      <= lane_new[2];
                r_res_h      <= lane_new[3];
                r_res_cnt    <= r_new_cnt;
                r_res_used   <= r_occ;
            end
            S_RLD: begin
                r_res_status <= ST_READ_OK;
                r_res_idx    <= r_ridx;
                r_res_class  <= r_chc_q[CLS_W-1:0];
                r_res_x      <= r_pos_q[VAL_W-1:0];
                r_res_y      <= r_pos_q[2*VAL_W-1:VAL_W];
                r_res_z      <= r_pos_q[3*VAL_W-1:2*VAL_W];
                r_res_h      <= r_chc_q[CLS_W+VAL_W-1:CLS_W];
                r_res_cnt    <= r_chc_q[CHC_W-1:CLS_W+VAL_W];
                r_res_used   <= r_occ;
            end
            default: begin
                r_res_status <= r_res_status;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    logic                   r_out_valid;
    logic [103:0]           r_out_data;
    logic [STS_W-1:0]       r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_user <= r_res_status;
            r_out_data <= {3'b000, r_res_used, r_res_cnt, r_res_h, r_res_z,
                           r_res_y, r_res_x, r_res_class, r_res_idx};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(TABLE_DEPTH))
        else $error("occupied count beyond table depth");

    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_hit |-> ({1'b0, r_i2} < r_occ))
        else $error("scan matched an unoccupied entry");

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MDIV) |-> (lane_done == '0 || lane_done == '1))
        else $error("mean lanes out of step");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == CMD_CLEAR) |=> (r_occ == '0))
        else $error("clear left entries occupied");

    a_added_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user == ST_ADDED) |-> (r_out_data[100:94] != '0))
        else $error("added item reports an empty table");

endmodule

`default_nettype wire

### rtl/oma_mean.sv
// Running-mean lane: (mean*n + val) / (n+1), truncated toward zero, radix-2 divider.
`timescale 1ns / 1ps
`default_nettype none

module oma_mean (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [oma_pkg::VAL_W-1:0]    i_mean,
    input  wire logic [oma_pkg::NCNT_W-1:0]          i_cnt,
    input  wire logic signed [oma_pkg::VAL_W-1:0]    i_val,
    output logic                                     o_done,
    output logic signed [oma_pkg::VAL_W-1:0]         o_mean
);
    import oma_pkg::*;

    localparam int PROD_W = VAL_W + NCNT_W + 1;   // signed product / numerator
    localparam int MAG_W  = PROD_W - 1;
    localparam int DEN_W  = NCNT_W + 1;
    localparam int STEP_W = $clog2(VAL_W);

    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_MUL  = 6'b000010,
        M_SUM  = 6'b000100,
        M_ABS  = 6'b001000,
        M_DIV  = 6'b010000,
        M_FIX  = 6'b100000
    } t_mstate;

    t_mstate                   r_state, n_state;
    logic signed [VAL_W-1:0]   r_a, r_v;
    logic [NCNT_W-1:0]         r_n;
    logic signed [PROD_W-1:0]  r_prod, r_num;
    logic                      r_neg;
    logic [DEN_W-1:0]          r_rem, r_den;
    logic [VAL_W-1:0]          r_quo;
    logic [STEP_W-1:0]         r_step;
    logic                      r_done;
    logic signed [VAL_W-1:0]   r_mean;

    logic [PROD_W-1:0]         mag;
    logic [DEN_W:0]            sh, diff;
    logic                      ge;

    // |num| <= (n+1)*2^15, so the top half of the magnitude is already below
    // the divisor and only VAL_W quotient bits are needed.
    assign mag  = r_num[PROD_W-1] ? PROD_W'(-r_num) : PROD_W'(r_num);
    assign sh   = {r_rem, r_quo[VAL_W-1]};
    assign ge   = sh >= {1'b0, r_den};
    assign diff = sh - {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE:  if (i_start) n_state = M_MUL;
            M_MUL:   n_state = M_SUM;
            M_SUM:   n_state = M_ABS;
            M_ABS:   n_state = M_DIV;
            M_DIV:   if (r_step == STEP_W'(VAL_W - 1)) n_state = M_FIX;
            M_FIX:   n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                r_a <= i_mean;
                r_n <= i_cnt;
                r_v <= i_val;
            end
            M_MUL: begin
                r_prod <= r_a * $signed({1'b0, r_n});
            end
            M_SUM: begin
                r_num <= r_prod + PROD_W'(r_v);
            end
            M_ABS: begin
                r_neg  <= r_num[PROD_W-1];
                r_rem  <= {1'b0, mag[MAG_W-1:VAL_W]};
                r_quo  <= mag[VAL_W-1:0];
                r_den  <= {1'b0, r_n} + DEN_W'(1);
                r_step <= '0;
            end
            M_DIV: begin
                r_rem  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
                r_quo  <= {r_quo[VAL_W-2:0], ge};
                r_step <= r_step + STEP_W'(1);
            end
            M_FIX: begin
                r_mean <= r_neg ? $signed(-r_quo) : $signed(r_quo);
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_mean = r_mean;

endmodule

`default_nettype wire

### verif/oma_checker.sv
// Scoreboard for the object merge accumulator: tracks the table and checks every result item.
`timescale 1ns / 1ps

module oma_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [oma_pkg::RAD_W-1:0]  i_cfg_wr_data,
    input  wire logic                       s_axis_tvalid,
    input  wire logic                       s_axis_tready,
    // [7:0] obj_class, [23:8] x_pos, [39:24] y_pos, [55:40] z_pos,
    // [71:56] obj_height, [77:72] read_index, [79:78] zero
    input  wire logic [79:0]                s_axis_tdata,
    // [1:0] command
    input  wire logic [oma_pkg::CMD_W-1:0]  s_axis_tuser,
    input  wire logic                       m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [5:0] entry_index, [13:6] entry_class, [29:14] mean_x, [45:30] mean_y,
    // [61:46] mean_z, [77:62] mean_height, [93:78] sample_count,
    // [100:94] entries_used, [103:101] zero
    input  wire logic [103:0]               m_axis_tdata,
    // [2:0] status
    input  wire logic [oma_pkg::STS_W-1:0]  m_axis_tuser,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_merges,
    output int                              o_drops
);
    import oma_pkg::*;

    typedef struct {
        logic [STS_W-1:0]        status;
        logic [IDX_W-1:0]        index;
        logic [CLS_W-1:0]        cls;
        logic signed [VAL_W-1:0] mx;
        logic signed [VAL_W-1:0] my;
        logic signed [VAL_W-1:0] mz;
        logic signed [VAL_W-1:0] mh;
        logic [NCNT_W-1:0]       count;
        logic [OCC_W-1:0]        used;
    } t_table_result;

    // tracked copy of the object table
    logic [RAD_W-1:0]        radius_sq;
    logic [CLS_W-1:0]        tbl_cls [TABLE_DEPTH];
    logic signed [VAL_W-1:0] tbl_x   [TABLE_DEPTH];
    logic signed [VAL_W-1:0] tbl_y   [TABLE_DEPTH];
    logic signed [VAL_W-1:0] tbl_z   [TABLE_DEPTH];
    logic signed [VAL_W-1:0] tbl_h   [TABLE_DEPTH];
    logic [NCNT_W-1:0]       tbl_n   [TABLE_DEPTH];
    int                      entries_used;

    t_table_result expected_q[$];
    int fails   = 0;
    int checked = 0;
    int merges  = 0;
    int drops   = 0;

    // (mean*n + new)/(n+1), quotient truncated toward zero
    function automatic logic signed [VAL_W-1:0] running_mean(
        logic signed [VAL_W-1:0] mean, logic [NCNT_W-1:0] n, logic signed [VAL_W-1:0] val);
        longint num;
        longint den;
        num = longint'(mean) * longint'(n) + longint'(val);
        den = longint'(n) + 1;
        return VAL_W'(num / den);
    endfunction

    function automatic t_table_result entry_result(logic [STS_W-1:0] status, int idx);
        t_table_result r;
        r.status = status;
        r.index  = IDX_W'(idx);
        r.cls    = tbl_cls[idx];
        r.mx     = tbl_x[idx];
        r.my     = tbl_y[idx];
        r.mz     = tbl_z[idx];
        r.mh     = tbl_h[idx];
        r.count  = tbl_n[idx];
        r.used   = '0;
        return r;
    endfunction

    function automatic t_table_result empty_result(logic [STS_W-1:0] status, int idx);
        t_table_result r;
        r = '{default: '0};
        r.status = status;
        r.index  = IDX_W'(idx);
        return r;
    endfunction

    function automatic void track_item(logic [CMD_W-1:0] cmd, logic [CLS_W-1:0] cls,
                                       logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] y,
                                       logic signed [VAL_W-1:0] z, logic signed [VAL_W-1:0] h,
                                       logic [IDX_W-1:0] ridx);
        t_table_result r;
        longint dx;
        longint dz;
        longint d2;
        logic [NCNT_W-1:0] n;
        bit hit;
        hit = 1'b0;
        case (cmd)
            CMD_ADD: begin
                // first entry of the same class inside the radius wins
                for (int i = 0; i < entries_used && !hit; i++) begin
                    if (tbl_cls[i] == cls) begin
                        dx = longint'(tbl_x[i]) - longint'(x);
                        dz = longint'(tbl_z[i]) - longint'(z);
                        d2 = dx * dx + dz * dz;
                        if (d2 <= longint'(radius_sq)) begin
                            n = tbl_n[i];
                            tbl_x[i] = running_mean(tbl_x[i], n, x);
                            tbl_y[i] = running_mean(tbl_y[i], n, y);
                            tbl_z[i] = running_mean(tbl_z[i], n, z);
                            tbl_h[i] = running_mean(tbl_h[i], n, h);
                            tbl_n[i] = (n == '1) ? n : n + 1'b1;
                            r = entry_result(ST_MERGED, i);
                            hit = 1'b1;
                        end
                    end
                end
                if (!hit) begin
                    if (entries_used < TABLE_DEPTH) begin
                        tbl_cls[entries_used] = cls;
                        tbl_x[entries_used]   = x;
                        tbl_y[entries_used]   = y;
                        tbl_z[entries_used]   = z;
                        tbl_h[entries_used]   = h;
                        tbl_n[entries_used]   = NCNT_W'(1);
                        r = entry_result(ST_ADDED, entries_used);
                        entries_used++;
                    end else begin
                        r = empty_result(ST_DROPPED, 0);
                    end
                end
            end
            CMD_CLEAR: begin
                entries_used = 0;
                r = empty_result(ST_CLEARED, 0);
            end
            CMD_READ: begin
                if (int'(ridx) < entries_used) begin
                    r = entry_result(ST_READ_OK, int'(ridx));
                end else begin
                    r = empty_result(ST_READ_BAD, int'(ridx));
                end
            end
            default: return;    // unknown command: no result
        endcase
        r.used = OCC_W'(entries_used);
        expected_q.push_back(r);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_table_result want;
        t_table_result got;
        if (!i_rst_n) begin
            radius_sq    = RADIUS_RESET;
            entries_used = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                radius_sq = i_cfg_wr_data;
            end
            // results first, so an item taken at this edge is never matched to itself
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.index  = m_axis_tdata[5:0];
                got.cls    = m_axis_tdata[13:6];
                got.mx     = m_axis_tdata[29:14];
                got.my     = m_axis_tdata[45:30];
                got.mz     = m_axis_tdata[61:46];
                got.mh     = m_axis_tdata[77:62];
                got.count  = m_axis_tdata[93:78];
                got.used   = m_axis_tdata[100:94];
                if (expected_q.size() == 0) begin
                    $error("result with no item waiting: status %0d, entry %0d",
                           got.status, got.index);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status",       want.status, got.status);
                    check_field("entry_index",  want.index,  got.index);
                    check_field("entry_class",  want.cls,    got.cls);
                    check_field("mean_x",       want.mx,     got.mx);
                    check_field("mean_y",       want.my,     got.my);
                    check_field("mean_z",       want.mz,     got.mz);
                    check_field("mean_height",  want.mh,     got.mh);
                    check_field("sample_count", want.count,  got.count);
                    check_field("entries_used", want.used,   got.used);
                    checked++;
                    if (want.status == ST_MERGED) merges++;
                    if (want.status == ST_DROPPED) drops++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                track_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8],
                           s_axis_tdata[39:24], s_axis_tdata[55:40], s_axis_tdata[71:56],
                           s_axis_tdata[77:72]);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
        o_merges     <= merges;
        o_drops      <= drops;
    end

endmodule

### verif/object_merge_accumulator_tb.sv
// Testbench top for the object merge accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module object_merge_accumulator_tb;
    import oma_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;   // unknown command, block ignores it

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int NUM_ANCHORS     = 8;
    localparam int SETTLE_CYCLES   = 120;    // settling wait before a radius write and at the drain
    localparam int LONG_HOLD       = 400;    // one long receiver hold-off
    localparam int LONG_HOLD_AT    = 300;    // items taken before that hold starts
    localparam int TIMEOUT_NS      = 20_000_000;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_wr_en    = 1'b0;
    logic [RAD_W-1:0]   i_cfg_wr_data  = '0;
    logic               s_axis_tvalid  = 1'b0;
    logic               s_axis_tready;
    logic [79:0]        s_axis_tdata   = '0;   // class, x, y, z, height, read index
    logic [CMD_W-1:0]   s_axis_tuser   = '0;   // command
    logic               m_axis_tvalid;
    logic               m_axis_tready  = 1'b0;
    logic [103:0]       m_axis_tdata;          // index, class, means, count, used
    logic [STS_W-1:0]   m_axis_tuser;          // status

    int fail_count;
    int pending;
    int results_checked;
    int merges_seen;
    int drops_seen;

    int items_accepted = 0;
    int cmd_count [4]  = '{default: 0};
    bit src_idle       = 1'b1;   // sender may insert gaps
    bit quiet_tail     = 1'b0;   // last phase: neither side idles

    // anchors that random adds cluster around, so merges happen often
    int anc_cls [NUM_ANCHORS];
    int anc_x   [NUM_ANCHORS];
    int anc_z   [NUM_ANCHORS];

    object_merge_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    oma_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (results_checked),
        .o_merges      (merges_seen),
        .o_drops       (drops_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still outstanding", pending);
        $display("FAIL");
        $finish;
    end

    // Offer one item and hold it until taken. Called at a rising edge; returns at
    // the accepting edge with tvalid still high, so back-to-back items never drop it.
    task automatic send_item(logic [CMD_W-1:0] cmd, int cls, int x, int y, int z, int h,
                             int ridx);
        if (src_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, 6'(ridx), 16'(h), 16'(z), 16'(y), 16'(x), 8'(cls)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_accepted++;
        cmd_count[cmd]++;
    endtask

    // Drop tvalid, wait until every result is back, let a possible ignored item
    // settle, then write the radius.
    task automatic set_radius(logic [RAD_W-1:0] radius);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= radius;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // full range, with the two extremes weighted up
    function automatic int pick_coord();
        case ($urandom_range(0, 7))
            0:       return 32767;
            1:       return -32768;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int near_coord(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // Result sink: random ready stretches and idle bursts, plus one long hold-off
    // while the sender keeps offering, so the block backs up and stalls its input.
    initial begin : result_sink
        bit held_long;
        held_long = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 48)) @(posedge i_clk);
            if (!held_long && items_accepted >= LONG_HOLD_AT) begin
                held_long = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 1) == 1) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [RAD_W-1:0] phase_radius [NUM_PHASES];
        int sent;
        int pick;
        int a;
        int spread;

        // zero, the maximum, the smallest nonzero, the reset value written back,
        // a wide radius and a random one
        phase_radius[0] = '0;
        phase_radius[1] = '1;
        phase_radius[2] = RAD_W'(1);
        phase_radius[3] = RADIUS_RESET;
        phase_radius[4] = RAD_W'(4_000_000);
        phase_radius[5] = {1'($urandom_range(0, 1)), 32'($urandom)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset radius (0.6 m squared) ----
        send_item(CMD_READ, 0, 0, 0, 0, 0, 63);                  // read on empty table
        send_item(CMD_READ, 255, -1, -1, -1, -1, 0);
        send_item(CMD_ADD, 0, 32767, -32768, -32768, 32767, 0);  // new entry at extremes
        // merge: y and height means of -1/2 truncate toward zero
        send_item(CMD_ADD, 0, 32667, 32767, -32718, -32768, 0);
        send_item(CMD_ADD, 255, -32768, 32767, 32767, -32768, 0);
        send_item(CMD_ADD, 1, -32768, 0, 32767, 0, 0);            // same spot, other class
        send_item(CMD_ADD, 255, -32615, -1, 32767, 5, 0);        // 153 away: inside radius
        send_item(CMD_ADD, 255, -32537, 7, 32767, 9, 0);         // 154 from mean: just outside
        send_item(CMD_ADD, 7, 0, 0, 0, 0, 0);
        send_item(CMD_ADD, 7, 200, 0, 0, 0, 0);
        send_item(CMD_ADD, 7, 100, 0, 0, 0, 0);                  // inside both, first wins
        send_item(CMD_ADD, 7, -3, 100, 0, -100, 0);
        send_item(CMD_NOP, 170, 12345, -2222, 777, -9, 21);      // ignored
        send_item(CMD_READ, 0, 0, 0, 0, 0, 4);
        send_item(CMD_READ, 0, 0, 0, 0, 0, 5);                   // last used entry
        send_item(CMD_READ, 0, 0, 0, 0, 0, 6);                   // first unused entry
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0, 0, 0, 0);
        send_item(CMD_ADD, 42, -5, 6, -7, 8, 0);                 // slot 0 reused

        // ---- random part, one phase per radius setting ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_radius(phase_radius[p]);
            quiet_tail = (p == NUM_PHASES - 1);
            for (int k = 0; k < NUM_ANCHORS; k++) begin
                anc_cls[k] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                                         : int'($urandom_range(0, 3));
                anc_x[k] = pick_coord();
                anc_z[k] = pick_coord();
            end
            send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
            sent = 1;
            // every other phase opens by filling the table past full
            if (p % 2 == 0) begin
                repeat (70) begin
                    send_item(CMD_ADD, $urandom_range(0, 255), pick_coord(), pick_coord(),
                              pick_coord(), pick_coord(), 0);
                    sent++;
                end
            end
            while (sent < ITEMS_PER_PHASE) begin
                if (sent % 40 == 0) src_idle = ($urandom_range(0, 2) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    send_item(CMD_CLEAR, $urandom_range(0, 255), pick_coord(), 0, 0, 0,
                              $urandom_range(0, 63));
                    sent++;
                end else if (pick < 17) begin
                    send_item(CMD_READ, $urandom_range(0, 255), pick_coord(), pick_coord(),
                              pick_coord(), pick_coord(), $urandom_range(0, 63));
                    sent++;
                end else if (pick < 19) begin
                    send_item(CMD_NOP, $urandom_range(0, 255), pick_coord(), pick_coord(),
                              pick_coord(), pick_coord(), $urandom_range(0, 63));
                end else if (pick < 30) begin
                    send_item(CMD_ADD, $urandom_range(0, 255), pick_coord(), pick_coord(),
                              pick_coord(), pick_coord(), $urandom_range(0, 63));
                    sent++;
                end else begin
                    // clustered add: exact hits, one-step offsets, near and far jitter
                    a = $urandom_range(0, NUM_ANCHORS - 1);
                    case ($urandom_range(0, 3))
                        0:       spread = 0;
                        1:       spread = 1;
                        2:       spread = 150;
                        default: spread = 2000;
                    endcase
                    send_item(CMD_ADD, anc_cls[a], near_coord(anc_x[a], spread), pick_coord(),
                              near_coord(anc_z[a], spread), pick_coord(),
                              $urandom_range(0, 63));
                    sent++;
                end
            end
        end

        // ---- drain ----
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d items (%0d add, %0d clear, %0d read, %0d unknown) over %0d radii.",
                 items_accepted, cmd_count[CMD_ADD], cmd_count[CMD_CLEAR],
                 cmd_count[CMD_READ], cmd_count[CMD_NOP], NUM_PHASES + 1);
        $display("Checked %0d results, including %0d merges and %0d drops on a full table.",
                 results_checked, merges_seen, drops_seen);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### object_merge_accumulator.f
rtl/oma_pkg.sv
rtl/oma_mean.sv
rtl/object_merge_accumulator.sv
verif/oma_checker.sv
verif/object_merge_accumulator_tb.sv
